/* design/usbcd_pkg.sv */
// Package for the USB configuration descriptor parser.
// Holds descriptor codes, the descriptor walk limit and the capture record type.
// No dependencies.
package usbcd_pkg;

   localparam int MaxDescriptors = 10;

   localparam logic [7:0] KIND_INTERFACE = 8'h04;
   localparam logic [7:0] KIND_ENDPOINT  = 8'h05;
   localparam logic [7:0] HID_CLASS      = 8'h03;
   localparam logic [7:0] HID_SUB_BOOT   = 8'h01;
   localparam logic [7:0] HID_PROTO_KBD  = 8'h01;
   localparam logic [7:0] HID_PROTO_MOUSE = 8'h02;
   localparam logic [7:0] MIN_LENGTH     = 8'd2;

   localparam logic [1:0] XFER_BULK      = 2'd2;
   localparam logic [1:0] XFER_INTERRUPT = 2'd3;

   localparam logic [1:0] DEVICE_OTHER    = 2'd0;
   localparam logic [1:0] DEVICE_KEYBOARD = 2'd1;
   localparam logic [1:0] DEVICE_MOUSE    = 2'd2;

   typedef struct packed {
      logic       have_interface;
      logic [7:0] iface_number;
      logic [7:0] iface_class;
      logic [7:0] iface_subclass;
      logic [7:0] iface_protocol;
      logic       bulk_found;
      logic [3:0] bulk_endpoint;
      logic       intr_found;
      logic [3:0] intr_endpoint;
      logic       bad_length;
   } capture_type;

endpackage

/* design/usbcd_walker.sv */
// Descriptor walker: follows length bytes and captures interface and endpoint fields.
// Depends on usbcd_pkg. Presents the capture as it stands after the current byte.
module usbcd_walker
   import usbcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output capture_type capture
);

   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  count_ff, count_in;
   logic        stopped_ff, stopped_in;
   logic        bad_ff, bad_in;
   logic        have_if_ff, have_if_in;
   logic [31:0] iface_ff, iface_in;
   logic [3:0]  ep_hold_ff, ep_hold_in;
   logic [4:0]  bulk_ff, bulk_in;
   logic [4:0]  intr_ff, intr_in;

   always_comb begin
      offset_in  = offset_ff;
      length_in  = length_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      bad_in     = bad_ff;
      have_if_in = have_if_ff;
      iface_in   = iface_ff;
      ep_hold_in = ep_hold_ff;
      bulk_in    = bulk_ff;
      intr_in    = intr_ff;
      if (!stopped_ff) begin
         if (offset_ff == 8'd0) begin
            if (count_ff >= 8'(MaxDescriptors)) begin
               stopped_in = 1'b1;
            end else if (data_byte < MIN_LENGTH) begin
               stopped_in = 1'b1;
               bad_in     = 1'b1;
            end else begin
               length_in = data_byte;
               count_in  = count_ff + 8'd1;
               offset_in = 8'd1;
            end
         end else begin
            if (offset_ff == 8'd1) begin
               if (data_byte == KIND_INTERFACE && !have_if_ff) begin
                  have_if_in = 1'b1;
                  kind_in    = data_byte;
               end else if (data_byte == KIND_ENDPOINT) begin
                  kind_in = data_byte;
               end else begin
                  kind_in = 8'd0;
               end
            end else if (kind_ff == KIND_INTERFACE) begin
               unique case (offset_ff)
                  8'd2:    iface_in[7:0]   = data_byte;
                  8'd5:    iface_in[15:8]  = data_byte;
                  8'd6:    iface_in[23:16] = data_byte;
                  8'd7:    iface_in[31:24] = data_byte;
                  default: iface_in = iface_ff;
               endcase
            end else if (kind_ff == KIND_ENDPOINT) begin
               if (offset_ff == 8'd2) begin
                  ep_hold_in = data_byte[3:0];
               end else if (offset_ff == 8'd3) begin
                  if (data_byte[1:0] == XFER_BULK) begin
                     bulk_in = {1'b1, ep_hold_ff};
                  end else if (data_byte[1:0] == XFER_INTERRUPT) begin
                     intr_in = {1'b1, ep_hold_ff};
                  end
               end
            end
            if ({1'b0, offset_ff} + 9'd1 >= {1'b0, length_ff}) begin
               offset_in = 8'd0;
            end else begin
               offset_in = offset_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         offset_ff  <= '0;
         length_ff  <= '0;
         kind_ff    <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         bad_ff     <= 1'b0;
         have_if_ff <= 1'b0;
         iface_ff   <= '0;
         ep_hold_ff <= '0;
         bulk_ff    <= '0;
         intr_ff    <= '0;
      end else if (take) begin
         offset_ff  <= offset_in;
         length_ff  <= length_in;
         kind_ff    <= kind_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         bad_ff     <= bad_in;
         have_if_ff <= have_if_in;
         iface_ff   <= iface_in;
         ep_hold_ff <= ep_hold_in;
         bulk_ff    <= bulk_in;
         intr_ff    <= intr_in;
      end
   end

   always_comb begin
      capture.have_interface = have_if_in;
      capture.iface_number   = iface_in[7:0];
      capture.iface_class    = iface_in[15:8];
      capture.iface_subclass = iface_in[23:16];
      capture.iface_protocol = iface_in[31:24];
      capture.bulk_found     = bulk_in[4];
      capture.bulk_endpoint  = bulk_in[3:0];
      capture.intr_found     = intr_in[4];
      capture.intr_endpoint  = intr_in[3:0];
      capture.bad_length     = bad_in;
   end

endmodule

/* design/usb_config_descriptor_parser.sv */
// Top level of the USB configuration descriptor parser.
// Depends on usbcd_pkg and usbcd_walker; adds the result register and handshake.
//
// Takes one descriptor byte per cycle; every byte is absorbed in the cycle it is
// accepted, so the parser sustains one request per clock. The byte marked last
// produces one response in the next cycle from the result register, carrying what
// the walk captured up to and including that byte, and the walker returns to its
// initial state so the next byte starts a new descriptor set. Requests are held
// off only while a response is waiting and the response side stalls.
module usb_config_descriptor_parser
   import usbcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_interface_found,
   output logic [7:0] rsp_interface_number,
   output logic [7:0] rsp_iface_class,
   output logic [7:0] rsp_iface_subclass,
   output logic [7:0] rsp_iface_protocol,
   output logic       rsp_bulk_found,
   output logic [3:0] rsp_bulk_endpoint,
   output logic       rsp_interrupt_found,
   output logic [3:0] rsp_interrupt_endpoint,
   output logic [1:0] rsp_device_kind,
   output logic       rsp_irq_wanted,
   output logic       rsp_malformed
);

   logic        take;
   logic        rsp_valid_ff;
   capture_type capture;
   capture_type result_ff;
   logic [1:0]  kind_in;
   logic [1:0]  kind_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   usbcd_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .capture   (capture)
   );

   always_comb begin
      kind_in = DEVICE_OTHER;
      if (capture.have_interface && capture.iface_class == HID_CLASS
          && capture.iface_subclass == HID_SUB_BOOT) begin
         if (capture.iface_protocol == HID_PROTO_KBD) begin
            kind_in = DEVICE_KEYBOARD;
         end else if (capture.iface_protocol == HID_PROTO_MOUSE) begin
            kind_in = DEVICE_MOUSE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_last_byte) begin
         result_ff <= capture;
         kind_ff   <= kind_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interface_found    = result_ff.have_interface;
   assign rsp_interface_number   = result_ff.iface_number;
   assign rsp_iface_class        = result_ff.iface_class;
   assign rsp_iface_subclass     = result_ff.iface_subclass;
   assign rsp_iface_protocol     = result_ff.iface_protocol;
   assign rsp_bulk_found         = result_ff.bulk_found;
   assign rsp_bulk_endpoint      = result_ff.bulk_endpoint;
   assign rsp_interrupt_found    = result_ff.intr_found;
   assign rsp_interrupt_endpoint = result_ff.intr_endpoint;
   assign rsp_device_kind        = kind_ff;
   assign rsp_irq_wanted         = kind_ff != DEVICE_OTHER;
   assign rsp_malformed          = result_ff.bad_length;

endmodule
